FILE: hdl/ohlc_pkg.sv
package ohlc_pkg;

	localparam int TIME_W  = 40;
	localparam int PRICE_W = 48;
	localparam int POOL_W  = 8;
	localparam int MIN_W   = 11;
	localparam int LEN_W   = 17;
	localparam int SEC_PER_MIN = 60;

	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic REG_SHORT = 1'b0;
	localparam logic REG_LONG  = 1'b1;

	typedef enum logic [1:0] {
		MODE_LOOKUP,
		MODE_SWEEP,
		MODE_FLUSH
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOOK,
		ST_ALLOC,
		ST_SCAN,
		ST_END
	} state_t;

	typedef struct packed {
		logic  live;
		mode_t mode;
	} tok_t;

	typedef struct packed {
		logic               action;
		logic [POOL_W-1:0]  pool;
		logic [PRICE_W-1:0] price;
		logic [PRICE_W-1:0] amount;
		logic [TIME_W-1:0]  event_time;
		logic [TIME_W-1:0]  now_time;
	} point_word_t;

	typedef struct packed {
		logic [POOL_W-1:0]  bar_pool;
		logic               bar_long;
		logic [TIME_W-1:0]  bar_time;
		logic [PRICE_W-1:0] bar_open;
		logic [PRICE_W-1:0] bar_high;
		logic [PRICE_W-1:0] bar_low;
		logic [PRICE_W-1:0] bar_close;
		logic [PRICE_W-1:0] bar_volume;
		logic               overflow_seen;
		logic               last;
	} bar_word_t;

	typedef struct packed {
		logic [POOL_W-1:0]  pool;
		logic               is_long;
		logic [TIME_W-1:0]  start;
		logic [PRICE_W-1:0] open_p;
		logic [PRICE_W-1:0] high_p;
		logic [PRICE_W-1:0] low_p;
		logic [PRICE_W-1:0] close_p;
		logic [PRICE_W-1:0] volume;
	} entry_t;

	typedef struct packed {
		logic [POOL_W-1:0]  pool;
		logic [PRICE_W-1:0] price;
		logic [PRICE_W-1:0] amount;
		logic [TIME_W-1:0]  now;
		logic [TIME_W-1:0]  start_s;
		logic [TIME_W-1:0]  start_l;
	} key_t;

	// Interval length in seconds; a zero register counts as one minute.
	function automatic logic [LEN_W-1:0] len_of(input logic [MIN_W-1:0] m);
		logic [LEN_W-1:0] mm;
		mm = (m == '0) ? LEN_W'(1) : LEN_W'(m);
		return LEN_W'(mm * LEN_W'(SEC_PER_MIN));
	endfunction

endpackage

FILE: hdl/ohlc_div.sv
module ohlc_div
	import ohlc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [TIME_W-1:0] dividend,
	input  logic [LEN_W-1:0]  divisor,
	output logic              done,
	output logic [LEN_W-1:0]  rem
);

	localparam int CNT_W = $clog2(TIME_W + 1);

	logic [TIME_W-1:0] num_q;
	logic [LEN_W:0]    rem_q;
	logic [LEN_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [LEN_W:0]    trial;

	// Restoring division, one quotient bit per cycle, keeping only the remainder.
	always_comb begin
		trial = {rem_q[LEN_W-1:0], num_q[TIME_W-1]};
		if (trial >= {1'b0, div_q}) begin
			trial = trial - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(TIME_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[TIME_W-2:0], 1'b0};
			rem_q <= trial;
		end
	end

	assign done = !busy_q && !go;
	assign rem  = rem_q[LEN_W-1:0];

endmodule

FILE: hdl/ohlc_cell.sv
module ohlc_cell
	import ohlc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  tok_t             tok_in,
	output tok_t             tok,
	input  key_t             key,
	input  logic [LEN_W-1:0] len_s,
	input  logic [LEN_W-1:0] len_l,
	input  logic             alloc_s,
	input  logic             alloc_l,
	output logic             match_s,
	output logic             match_l,
	output logic             free,
	output logic             hit,
	output entry_t           entry
);

	tok_t              tok_q;
	logic              valid_q;
	entry_t            ent_q;
	logic              look;
	logic              same;
	logic [TIME_W:0]   end_t;
	logic              expired;
	logic [PRICE_W:0]  vsum;
	logic [PRICE_W-1:0] vsat;

	always_comb begin
		look    = tok_q.live && (tok_q.mode == MODE_LOOKUP);
		same    = valid_q && (ent_q.pool == key.pool);
		match_s = look && same && !ent_q.is_long && (ent_q.start == key.start_s);
		match_l = look && same && ent_q.is_long && (ent_q.start == key.start_l);
		free    = look && !valid_q;
		end_t   = {1'b0, ent_q.start} +
			{(TIME_W + 1 - LEN_W)'(0), (ent_q.is_long ? len_l : len_s)};
		expired = {1'b0, key.now} >= end_t;
		hit     = 1'b0;
		case (tok_q.mode)
			MODE_SWEEP: hit = tok_q.live && valid_q && expired;
			MODE_FLUSH: hit = tok_q.live && valid_q;
			default:    hit = 1'b0;
		endcase
		vsum = {1'b0, ent_q.volume} + {1'b0, key.amount};
		vsat = vsum[PRICE_W] ? '1 : vsum[PRICE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '{live: 1'b0, mode: MODE_LOOKUP};
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (alloc_s || alloc_l) begin
				valid_q <= 1'b1;
			end else if (adv && hit) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_s || alloc_l) begin
			ent_q.pool    <= key.pool;
			ent_q.is_long <= alloc_l;
			ent_q.start   <= alloc_l ? key.start_l : key.start_s;
			ent_q.open_p  <= key.price;
			ent_q.high_p  <= key.price;
			ent_q.low_p   <= key.price;
			ent_q.close_p <= key.price;
			ent_q.volume  <= key.amount;
		end else if (match_s || match_l) begin
			if (key.price > ent_q.high_p) begin
				ent_q.high_p <= key.price;
			end
			if (key.price < ent_q.low_p) begin
				ent_q.low_p <= key.price;
			end
			ent_q.close_p <= key.price;
			ent_q.volume  <= vsat;
		end
	end

	assign tok   = tok_q;
	assign entry = ent_q;

endmodule

FILE: hdl/ohlc_bar_aggregator_unit.sv
// OHLCV bar aggregator. Price points come in on the point channel, one word
// per point, with point_valid and point_stall; finished bars leave on the bar
// channel, one word per bar, with bar_valid and bar_stall. Each point is folded
// into a short-interval bar and a long-interval bar of its pool, held in a row
// of ENTRIES cells. Interval lengths are set over the APB port.
// A valid point takes these steps: two remainder units floor the event time,
// then a token walks the cell row once to look up both keys (one cell a
// cycle), the ALLOC state writes new bars, and a second walk sweeps the row
// for finished bars. A flush is a single walk of the row. A point with zero
// price or an out-of-range pool is dropped in the cycle it is accepted. One
// point is worked on at a time; point_stall is high until the last bar of a
// point is in the output register. Bars appear in cell order; the last one
// of a point carries last. When the receiver holds bar_stall, one bar waits
// in the output register and one more in a holding register; the sweep walk
// then pauses on the next finished cell until space frees up. Reset empties
// every cell, clears the sticky overflow flag and loads the interval
// registers with 5 and 15 minutes.
module ohlc_bar_aggregator_unit
	import ohlc_pkg::*;
#(
	parameter int ENTRIES = 32,
	parameter int POOLS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        point_valid,
	output logic        point_stall,
	input  point_word_t point,
	output logic        bar_valid,
	input  logic        bar_stall,
	output bar_word_t   bar,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(ENTRIES);
	localparam logic [16:0] POOL_LIM = 17'(POOLS);

	// Configuration registers.
	logic [MIN_W-1:0] short_min_q;
	logic [MIN_W-1:0] long_min_q;
	logic [LEN_W-1:0] len_s;
	logic [LEN_W-1:0] len_l;

	assign pready = 1'b1;
	assign prdata = {(32 - MIN_W)'(0), (paddr[2] == REG_LONG) ? long_min_q : short_min_q};
	assign len_s  = len_of(short_min_q);
	assign len_l  = len_of(long_min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= MIN_W'(5);
			long_min_q  <= MIN_W'(15);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_LONG) begin
				long_min_q <= pwdata[MIN_W-1:0];
			end else begin
				short_min_q <= pwdata[MIN_W-1:0];
			end
		end
	end

	// Control state.
	state_t          state_q, state_d;
	logic            accept;
	logic            point_ok;
	logic            launch;
	mode_t           launch_mode;
	logic            div_go;
	logic            adv;
	logic            do_alloc;
	logic            push_last;
	logic            take;
	logic            div_done_s, div_done_l;
	logic [LEN_W-1:0] rem_s, rem_l;

	key_t              key_q;
	logic [TIME_W-1:0] t_q;
	logic [IW-1:0]     pos_q;
	logic              matched_s_q, matched_l_q;
	logic              f1_v_q, f2_v_q;
	logic [IW-1:0]     f1_q, f2_q;
	logic              overflow_q;

	bar_word_t pend_q;
	logic      pend_v_q;
	bar_word_t fin_bar;
	bar_word_t out_q;
	logic      out_v_q;
	logic      out_free;

	// Cell row.
	tok_t          tok_a [ENTRIES];
	entry_t        ent_a [ENTRIES];
	logic [ENTRIES-1:0] live_v, hit_v, free_v, ms_v, ml_v, al_s_v, al_l_v;
	tok_t          launch_tok;
	entry_t        sel_ent;
	logic          hit_any;

	logic          s_new, l_new, s_ok, l_ok;
	logic [IW-1:0] l_idx;

	assign launch_tok = '{live: launch, mode: launch_mode};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tok_t tin;
		if (i == 0) begin : g_head
			assign tin = launch_tok;
		end else begin : g_link
			assign tin = tok_a[i-1];
		end
		ohlc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tin),
			.tok     (tok_a[i]),
			.key     (key_q),
			.len_s   (len_s),
			.len_l   (len_l),
			.alloc_s (al_s_v[i]),
			.alloc_l (al_l_v[i]),
			.match_s (ms_v[i]),
			.match_l (ml_v[i]),
			.free    (free_v[i]),
			.hit     (hit_v[i]),
			.entry   (ent_a[i])
		);
		assign live_v[i] = tok_a[i].live;
		assign al_s_v[i] = do_alloc && s_new && s_ok && (f1_q == IW'(i));
		assign al_l_v[i] = do_alloc && l_new && l_ok && (l_idx == IW'(i));
	end

	// Only the cell holding the token can report a hit.
	always_comb begin
		sel_ent = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			sel_ent = sel_ent | (ent_a[i] & {$bits(entry_t){live_v[i]}});
		end
		hit_any = |hit_v;
	end

	ohlc_div u_div_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (point.event_time),
		.divisor  (len_s),
		.done     (div_done_s),
		.rem      (rem_s)
	);

	ohlc_div u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (point.event_time),
		.divisor  (len_l),
		.done     (div_done_l),
		.rem      (rem_l)
	);

	// The short bar takes the lowest free cell; the long bar takes the next
	// one if the short bar had to be opened, otherwise the lowest.
	always_comb begin
		s_new = !matched_s_q;
		l_new = !matched_l_q;
		s_ok  = f1_v_q;
		l_idx = (s_new && f1_v_q) ? f2_q : f1_q;
		l_ok  = (s_new && f1_v_q) ? f2_v_q : f1_v_q;
	end

	// The held bar with its last mark set, for the final bar of a word.
	always_comb begin
		fin_bar      = pend_q;
		fin_bar.last = 1'b1;
	end

	assign point_stall = (state_q != ST_IDLE);
	assign accept      = point_valid && !point_stall;
	assign point_ok    = (point.price != '0) && ({9'd0, point.pool} < POOL_LIM);
	assign out_free    = !out_v_q || !bar_stall;
	assign take        = (state_q == ST_SCAN) && adv && hit_any;

	always_comb begin
		state_d     = state_q;
		launch      = 1'b0;
		launch_mode = MODE_LOOKUP;
		div_go      = 1'b0;
		adv         = 1'b1;
		do_alloc    = 1'b0;
		push_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (point.action == ACT_FLUSH) begin
						launch      = 1'b1;
						launch_mode = MODE_FLUSH;
						state_d     = ST_SCAN;
					end else if (point_ok) begin
						div_go  = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done_s && div_done_l) begin
					launch  = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (live_v[ENTRIES-1]) begin
					state_d = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				do_alloc    = 1'b1;
				launch      = 1'b1;
				launch_mode = MODE_SWEEP;
				state_d     = ST_SCAN;
			end
			ST_SCAN: begin
				adv = !(hit_any && pend_v_q && !out_free);
				if (adv && live_v[ENTRIES-1]) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			matched_s_q <= 1'b0;
			matched_l_q <= 1'b0;
			f1_v_q      <= 1'b0;
			f2_v_q      <= 1'b0;
			overflow_q  <= 1'b0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (launch) begin
				pos_q <= '0;
			end else if (adv && (|live_v)) begin
				pos_q <= pos_q + IW'(1);
			end
			if (launch && (launch_mode == MODE_LOOKUP)) begin
				matched_s_q <= 1'b0;
				matched_l_q <= 1'b0;
				f1_v_q      <= 1'b0;
				f2_v_q      <= 1'b0;
			end else if (state_q == ST_LOOK) begin
				if (|ms_v) begin
					matched_s_q <= 1'b1;
				end
				if (|ml_v) begin
					matched_l_q <= 1'b1;
				end
				if (|free_v) begin
					if (!f1_v_q) begin
						f1_v_q <= 1'b1;
					end else if (!f2_v_q) begin
						f2_v_q <= 1'b1;
					end
				end
			end
			if (do_alloc && ((s_new && !s_ok) || (l_new && !l_ok))) begin
				overflow_q <= 1'b1;
			end
			if (push_last || (take && pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (!bar_stall) begin
				out_v_q <= 1'b0;
			end
			if (push_last) begin
				pend_v_q <= 1'b0;
			end else if (take) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.pool   <= point.pool;
			key_q.price  <= point.price;
			key_q.amount <= point.amount;
			key_q.now    <= point.now_time;
			t_q          <= point.event_time;
		end
		if ((state_q == ST_DIV) && div_done_s && div_done_l) begin
			key_q.start_s <= t_q - {(TIME_W - LEN_W)'(0), rem_s};
			key_q.start_l <= t_q - {(TIME_W - LEN_W)'(0), rem_l};
		end
		if ((state_q == ST_LOOK) && (|free_v)) begin
			if (!f1_v_q) begin
				f1_q <= pos_q;
			end else if (!f2_v_q) begin
				f2_q <= pos_q;
			end
		end
		if (push_last) begin
			out_q <= fin_bar;
		end else if (take && pend_v_q) begin
			out_q <= pend_q;
		end
		if (take) begin
			pend_q.bar_pool      <= sel_ent.pool;
			pend_q.bar_long      <= sel_ent.is_long;
			pend_q.bar_time      <= sel_ent.start;
			pend_q.bar_open      <= sel_ent.open_p;
			pend_q.bar_high      <= sel_ent.high_p;
			pend_q.bar_low       <= sel_ent.low_p;
			pend_q.bar_close     <= sel_ent.close_p;
			pend_q.bar_volume    <= sel_ent.volume;
			pend_q.overflow_seen <= overflow_q;
			pend_q.last          <= 1'b0;
		end
	end

	assign bar_valid = out_v_q;
	assign bar       = out_q;

endmodule
